// File: rtl/core/ssc_pkg.sv
// ssc_pkg: shared types and sizing constants for the stack sortability checker
// no dependencies; used by ssc_front, ssc_back and stack_sortability_checker

package ssc_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int VALUE_W     = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int M_TDATA_W   = 8;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last_item;
    } item_t;

    typedef struct packed {
        logic sortable;
        logic overflow;
    } verdict_t;

endpackage

// File: rtl/core/ssc_front.sv
// ssc_front: input side, accepts stream transactions into a two-entry queue
// depends on ssc_pkg

module ssc_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ssc_pkg::VALUE_W-1:0]       s_tdata,
    input  logic                              s_tlast,
    output logic                              q_valid,
    output ssc_pkg::item_t                    q_item,
    input  logic                              q_pop
);

    ssc_pkg::item_t                   entry_reg [ssc_pkg::QUEUE_DEPTH];
    logic [ssc_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [ssc_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [ssc_pkg::QCNT_W-1:0]       count_reg, count_next;
    logic                             push, pop;

    assign s_tready = (count_reg != ssc_pkg::QCNT_W'(ssc_pkg::QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_item   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= '{value: $signed(s_tdata), last_item: s_tlast};
        end
    end

endmodule

// File: rtl/core/ssc_back.sv
// ssc_back: stack engine, one pop or one push per cycle unless a waiting verdict stalls it, holds the verdict register
// depends on ssc_pkg; stack entries below the top live in a local memory

module ssc_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    input  ssc_pkg::item_t       q_item,
    output logic                 q_pop,
    output logic                 out_valid,
    output ssc_pkg::verdict_t    out_verdict,
    input  logic                 out_ready
);

    logic signed [ssc_pkg::VALUE_W-1:0] mem [ssc_pkg::STACK_DEPTH];

    logic [ssc_pkg::LEVEL_W-1:0]        level_reg, level_next;
    logic signed [ssc_pkg::VALUE_W-1:0] top_reg, top_next;
    logic signed [ssc_pkg::VALUE_W-1:0] last_out_reg, last_out_next;
    logic                               seen_reg, seen_next;
    logic                               failed_reg, failed_next;
    logic                               ovf_reg, ovf_next;
    logic                               out_valid_reg, out_valid_next;
    ssc_pkg::verdict_t                  verdict_reg, verdict_next;

    logic signed [ssc_pkg::VALUE_W-1:0] rdata_reg;
    logic signed [ssc_pkg::VALUE_W-1:0] byp_data_reg;
    logic                               byp_reg;
    logic signed [ssc_pkg::VALUE_W-1:0] second;

    logic                               wr_en;
    logic [ssc_pkg::ADDR_W-1:0]         waddr, raddr;
    logic [ssc_pkg::LEVEL_W-1:0]        level_m1, raddr_full;
    logic                               pop_cond, slot_free, fail_now, do_push;

    assign second    = byp_reg ? byp_data_reg : rdata_reg;
    assign slot_free = !out_valid_reg || out_ready;
    assign pop_cond  = q_valid && (level_reg != '0) && (top_reg < q_item.value);
    assign fail_now  = q_valid && seen_reg && (q_item.value < last_out_reg);
    assign do_push   = q_valid && !pop_cond && (slot_free || !q_item.last_item);
    assign q_pop     = do_push;
    assign level_m1  = level_reg - 1'b1;
    assign waddr     = level_m1[ssc_pkg::ADDR_W-1:0];

    always_comb begin
        level_next     = level_reg;
        top_next       = top_reg;
        last_out_next  = last_out_reg;
        seen_next      = seen_reg;
        failed_next    = failed_reg || fail_now;
        ovf_next       = ovf_reg;
        wr_en          = 1'b0;
        if (pop_cond) begin
            last_out_next = top_reg;
            seen_next     = 1'b1;
            top_next      = second;
            level_next    = level_m1;
        end else if (do_push) begin
            if (level_reg == ssc_pkg::LEVEL_W'(ssc_pkg::STACK_DEPTH)) begin
                ovf_next    = 1'b1;
                failed_next = 1'b1;
            end else begin
                wr_en      = (level_reg != '0);
                top_next   = q_item.value;
                level_next = level_reg + 1'b1;
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg && !out_ready;
        verdict_next   = verdict_reg;
        if (do_push && q_item.last_item) begin
            out_valid_next = 1'b1;
            verdict_next   = '{sortable: !failed_next, overflow: ovf_next};
        end
    end

    assign raddr_full = level_next - ssc_pkg::LEVEL_W'(2);
    assign raddr      = raddr_full[ssc_pkg::ADDR_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg     <= '0;
            last_out_reg  <= '0;
            seen_reg      <= 1'b0;
            failed_reg    <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (do_push && q_item.last_item) begin
                level_reg    <= '0;
                last_out_reg <= '0;
                seen_reg     <= 1'b0;
                failed_reg   <= 1'b0;
                ovf_reg      <= 1'b0;
            end else begin
                level_reg    <= level_next;
                last_out_reg <= last_out_next;
                seen_reg     <= seen_next;
                failed_reg   <= failed_next;
                ovf_reg      <= ovf_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        top_reg      <= top_next;
        verdict_reg  <= verdict_next;
        byp_reg      <= wr_en && (waddr == raddr);
        byp_data_reg <= top_reg;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[waddr] <= top_reg;
        end
        rdata_reg <= mem[raddr];
    end

    assign out_valid   = out_valid_reg;
    assign out_verdict = verdict_reg;

`ifndef ASSERT_OFF
    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= ssc_pkg::LEVEL_W'(ssc_pkg::STACK_DEPTH))
        else $error("stack level beyond depth");

    a_ovf_fails: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> failed_reg)
        else $error("overflow without fail");

    a_pop_level: assert property (@(posedge aclk) disable iff (!aresetn)
        pop_cond |=> level_reg == $past(level_reg) - 1'b1)
        else $error("pop did not lower level");

    a_last_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && q_item.last_item) |=> out_valid_reg && level_reg == '0)
        else $error("last transaction gave no verdict");

    a_no_pop_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        pop_cond |-> !q_pop)
        else $error("queue popped during stack pop");
`endif

endmodule

// File: rtl/core/stack_sortability_checker.sv
// stack_sortability_checker: top level, joins the input queue and the stack engine
// depends on ssc_pkg, ssc_front, ssc_back
//
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  s_tdata[31:0] value (signed), s_tlast last_item
// m_       out  m_tvalid/m_tready  m_tdata[0] sortable, [1] overflow, [7:2] zero
//
// each cycle the stack engine does one pop or one push while the queue holds a value,
// unless a waiting verdict holds back a last transaction; a value is taken only after
// every stack entry it pops, and every value is popped at most once
// a verdict appears in the cycle after the engine takes the last transaction
// reset is synchronous, active low, and empties the stack at once
// a waiting verdict stalls the engine only on the next last transaction

module stack_sortability_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ssc_pkg::VALUE_W-1:0]      s_tdata,   // value
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ssc_pkg::M_TDATA_W-1:0]    m_tdata    // sortable, overflow, zero fill
);

    logic              q_valid;
    logic              q_pop;
    ssc_pkg::item_t    q_item;
    ssc_pkg::verdict_t verdict;

    ssc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    ssc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .out_valid   (m_tvalid),
        .out_verdict (verdict),
        .out_ready   (m_tready)
    );

    assign m_tdata = {{(ssc_pkg::M_TDATA_W - 2){1'b0}}, verdict.overflow, verdict.sortable};

endmodule

// File: dv/stack_verdict_checker.sv
// stack_verdict_checker: follows the input and verdict channels of the stack sortability checker
// keeps its own stack model, predicts each verdict and compares it with the one the block returns
// depends on ssc_pkg

module stack_verdict_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [ssc_pkg::VALUE_W-1:0]   s_tdata,   // value
    input  logic                          s_tlast,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [ssc_pkg::M_TDATA_W-1:0] m_tdata,   // sortable, overflow, zero fill
    output int                            mismatch_count,
    output int                            verdicts_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic signed [ssc_pkg::VALUE_W-1:0] stack_mem [ssc_pkg::STACK_DEPTH];
    int                                 stack_level;
    logic signed [ssc_pkg::VALUE_W-1:0] last_out;
    logic                               seen_output;
    logic                               seq_failed;
    logic                               seq_overflowed;
    ssc_pkg::verdict_t                  pending_verdicts[$];

    function automatic void clear_sequence();
        stack_level    = 0;
        last_out       = '0;
        seen_output    = 1'b0;
        seq_failed     = 1'b0;
        seq_overflowed = 1'b0;
    endfunction

    function automatic void absorb_value(input logic signed [ssc_pkg::VALUE_W-1:0] v,
                                         input logic last);
        ssc_pkg::verdict_t vd;
        if (seen_output && v < last_out) begin
            seq_failed = 1'b1;
        end
        while (stack_level > 0 && stack_mem[stack_level-1] < v) begin
            stack_level--;
            last_out    = stack_mem[stack_level];
            seen_output = 1'b1;
        end
        if (stack_level >= ssc_pkg::STACK_DEPTH) begin
            seq_overflowed = 1'b1;
            seq_failed     = 1'b1;
        end else begin
            stack_mem[stack_level] = v;
            stack_level++;
        end
        if (last) begin
            vd.sortable = !seq_failed;
            vd.overflow = seq_overflowed;
            pending_verdicts.push_back(vd);
            clear_sequence();
        end
    endfunction

    always @(posedge aclk) begin
        ssc_pkg::verdict_t got;
        ssc_pkg::verdict_t want;
        if (!aresetn) begin
            clear_sequence();
            pending_verdicts.delete();
        end else begin
            // verdicts first, so one taken at this edge never matches its own last value
            if (m_tvalid && m_tready) begin
                got.sortable = m_tdata[0];
                got.overflow = m_tdata[1];
                if (pending_verdicts.size() == 0) begin
                    $error("unexpected verdict: sortable %0b, overflow %0b",
                           got.sortable, got.overflow);
                    mismatch_count++;
                end else begin
                    want = pending_verdicts.pop_front();
                    if (got.sortable !== want.sortable) begin
                        $error("sortable: expected %0b, actual %0b", want.sortable, got.sortable);
                        mismatch_count++;
                    end
                    if (got.overflow !== want.overflow) begin
                        $error("overflow: expected %0b, actual %0b", want.overflow, got.overflow);
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                absorb_value(s_tdata, s_tlast);
            end
        end
        verdicts_pending <= pending_verdicts.size();
    end

endmodule

// File: dv/tb_stack_sortability_checker.sv
// tb_stack_sortability_checker: drives value sequences into the stack sortability checker
// under several idle and stall mixes and reports the verdict of stack_verdict_checker
// depends on ssc_pkg, stack_sortability_checker, stack_verdict_checker

module tb_stack_sortability_checker;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     TOTAL_ITEMS    = 1400;
    localparam int     PHASE_ITEMS    = 90;
    localparam int     WATCHDOG_LIMIT = 20000;
    localparam int     SETTLE_CYCLES  = 40;
    localparam int     VMIN           = 32'sh8000_0000;
    localparam int     VMAX           = 32'sh7fff_ffff;
    localparam longint INT_LO         = -64'sd2147483648;
    localparam longint INT_HI         = 64'sd2147483647;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [ssc_pkg::VALUE_W-1:0]   s_tdata  = '0;   // value
    logic                          s_tlast  = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [ssc_pkg::M_TDATA_W-1:0] m_tdata;         // sortable, overflow, zero fill

    int mismatch_count;
    int verdicts_pending;
    int items_sent   = 0;
    int rand_base    = 0;
    int src_idle     = 0;
    int sink_stall   = 0;
    int quiet_cycles = 0;
    int idle_table [4] = '{0, 78, 0, 14};
    int stall_table[4] = '{0, 0, 78, 14};

    always #1 aclk = ~aclk;

    stack_sortability_checker dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    stack_verdict_checker verdict_chk (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tlast          (s_tlast),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .mismatch_count   (mismatch_count),
        .verdicts_pending (verdicts_pending)
    );

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic void set_pace(input int p);
        src_idle   = idle_table[p];
        sink_stall = stall_table[p];
    endfunction

    function automatic int pick_value();
        case ($urandom_range(9))
            0:       return VMIN;
            1:       return VMAX;
            2:       return 0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    // 231-avoiding order of ranks lo..hi, exactly the ones a single stack can sort
    function automatic void nest_ranks(input int lo, input int hi, ref int ranks[$]);
        int split;
        if (lo > hi) return;
        split = $urandom_range(hi - lo);
        nest_ranks(lo, lo + split - 1, ranks);
        ranks.push_back(hi);
        nest_ranks(lo + split, hi - 1, ranks);
    endfunction

    // n distinct ascending values with a random spacing scale
    function automatic void draw_ladder(input int n, ref int rungs[$]);
        longint step_max;
        longint ceiling;
        longint cur;
        step_max = 64'd1 << (2 * $urandom_range(13));
        ceiling  = INT_HI - longint'(n) * step_max;
        cur      = ($urandom_range(3) == 0) ? INT_LO
                 : INT_LO + longint'($urandom_range(0, 32'(ceiling - INT_LO)));
        rungs.delete();
        for (int i = 0; i < n; i++) begin
            rungs.push_back(int'(cur));
            cur += longint'($urandom_range(1, 32'(step_max)));
        end
        if ($urandom_range(3) == 0) rungs[n-1] = VMAX;
    endfunction

    task automatic feed_value(input int v, input logic last);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic play_list(input int seq[$]);
        foreach (seq[i]) feed_value(seq[i], i == seq.size() - 1);
    endtask

    // strictly falling run that fills the stack; top_off ends it with a value that pops everything
    task automatic play_descent(input int n, input logic top_off);
        int v;
        v = $urandom_range(1 << 30);
        for (int i = 0; i < n; i++) begin
            feed_value(v, (i == n - 1) && !top_off);
            v -= $urandom_range(1, 1000);
        end
        if (top_off) feed_value(VMAX, 1'b1);
    endtask

    task automatic play_random_sequence();
        int ranks[$];
        int rungs[$];
        int n;
        int kind;
        int a;
        int b;
        int tmp;
        n    = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        kind = $urandom_range(99);
        if (kind < 85) begin
            draw_ladder(n, rungs);
            nest_ranks(0, n - 1, ranks);
            if (kind >= 60 && kind < 75) begin
                // one swapped pair, usually breaks sortability
                a = $urandom_range(n - 1);
                b = $urandom_range(n - 1);
                tmp = ranks[a];
                ranks[a] = ranks[b];
                ranks[b] = tmp;
            end else if (kind >= 75) begin
                for (int i = n - 1; i > 0; i--) begin
                    a = $urandom_range(i);
                    tmp = ranks[i];
                    ranks[i] = ranks[a];
                    ranks[a] = tmp;
                end
            end
            for (int i = 0; i < n; i++) feed_value(rungs[ranks[i]], i == n - 1);
        end else begin
            // noise with repeats and extremes
            for (int i = 0; i < n; i++) begin
                feed_value($urandom_range(1) ? pick_value() : int'($urandom_range(7)) - 4,
                           i == n - 1);
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        set_pace(0);
        play_list('{VMIN});
        play_list('{VMAX});
        play_list('{1, 3, 4, 2});
        play_list('{-5, -7});
        play_list('{3, 1, 2});
        play_list('{2, 3, 1});
        play_list('{4, 4, 4});
        play_list('{VMAX, VMIN, 0});
        play_list('{VMIN, VMAX, VMIN});

        set_pace(3);
        play_descent(ssc_pkg::STACK_DEPTH + 1, 1'b1);

        rand_base = items_sent;
        while (items_sent < TOTAL_ITEMS) begin
            set_pace(((items_sent - rand_base) / PHASE_ITEMS) % 4);
            play_random_sequence();
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        wait (verdicts_pending == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/ssc_pkg.sv
rtl/core/ssc_front.sv
rtl/core/ssc_back.sv
rtl/core/stack_sortability_checker.sv
dv/stack_verdict_checker.sv
dv/tb_stack_sortability_checker.sv
